// ----- hw/rtl/ppid_pkg.sv -----
// Shared types, constants and helper functions for the position PID
// controller. No dependencies.
`default_nettype none

package ppid_pkg;

	localparam int SINE_TABLE_DEPTH = 256;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint INV_TWO_PI_Q32 = 64'sd683565276;

	localparam logic [23:0] P_GAIN_RESET = 24'd65536;
	localparam logic [23:0] GAIN_ZERO = 24'd0;
	localparam logic [31:0] THRUST_LIMITS_RESET = 32'd1932726108;
	localparam logic [31:0] HOVER_TILT_RESET = 32'd843333632;

	typedef enum logic [2:0] {
		CFG_P_GAIN_XY = 3'd0,
		CFG_P_GAIN_Z = 3'd1,
		CFG_I_GAIN_XY = 3'd2,
		CFG_I_GAIN_Z = 3'd3,
		CFG_D_GAIN_XY = 3'd4,
		CFG_D_GAIN_Z = 3'd5,
		CFG_THRUST_LIMITS = 3'd6,
		CFG_HOVER_AND_TILT = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_INC,
		ST_ROM,
		ST_PROD,
		ST_ROT,
		ST_CLAMP
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic sum_en;
		logic inc_en;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] measured_x;
		logic signed [31:0] measured_y;
		logic signed [31:0] measured_z;
		logic signed [31:0] error_rate_x;
		logic signed [31:0] error_rate_y;
		logic signed [31:0] error_rate_z;
		logic signed [15:0] heading;
		logic [23:0] time_step;
		logic [2:0] reset_flags;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic [15:0] thrust_out;
		logic [2:0] saturated;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Sine of x (radians, Q2.30, first quadrant) as Q1.15 by a Taylor series.
	function automatic logic signed [16:0] sin_poly(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		return 17'((longint'(sum) + 64'sd16384) >>> 15);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ppid_lane.sv -----
// One axis of the PID: proportional, derivative and integral products,
// force sum and integrator increment. Depends on ppid_pkg.
`default_nettype none

module ppid_lane (
	input  wire logic                 clk,
	input  wire ppid_pkg::lane_ctl_t  ctl,
	input  wire logic signed [31:0]   target,
	input  wire logic signed [31:0]   measured,
	input  wire logic signed [31:0]   rate,
	input  wire logic [23:0]          p_gain,
	input  wire logic [23:0]          i_gain,
	input  wire logic [23:0]          d_gain,
	input  wire logic signed [31:0]   integ,
	input  wire logic [23:0]          time_step,
	output logic signed [31:0]        force_out,
	output logic signed [32:0]        incr
);

	logic signed [32:0] err;
	logic signed [57:0] p_prod_s1;
	logic signed [57:0] i_prod_s1;
	logic signed [56:0] d_prod_s1;
	logic signed [43:0] fsum;
	logic signed [31:0] force_s2;
	logic signed [31:0] inc0_s2;
	logic signed [56:0] dt_prod;
	logic signed [32:0] inc_s3;

	assign err = 33'(target) - 33'(measured);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			p_prod_s1 <= err * $signed({1'b0, p_gain});
			i_prod_s1 <= err * $signed({1'b0, i_gain});
			d_prod_s1 <= rate * $signed({1'b0, d_gain});
		end
	end

	assign fsum = 44'(p_prod_s1 >>> 16) + 44'(d_prod_s1 >>> 16) + 44'(integ);

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			force_s2 <= ppid_pkg::sat32(64'(fsum));
			inc0_s2 <= ppid_pkg::sat32(64'(i_prod_s1 >>> 16));
		end
	end

	assign dt_prod = inc0_s2 * $signed({1'b0, time_step});

	always_ff @(posedge clk) begin
		if (ctl.inc_en) begin
			inc_s3 <= 33'(dt_prod >>> 24);
		end
	end

	assign force_out = force_s2;
	assign incr = inc_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/ppid_sine_rom.sv -----
// Constant sine and cosine table, one entry per step of a full turn, with a
// registered read. Depends on ppid_pkg.
`default_nettype none

module ppid_sine_rom #(
	parameter int DEPTH = ppid_pkg::SINE_TABLE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   idx,
	output logic signed [16:0]              sin_val,
	output logic signed [16:0]              cos_val
);

	logic signed [16:0] sin_tab [DEPTH];
	logic signed [16:0] cos_tab [DEPTH];
	logic signed [16:0] sin_q;
	logic signed [16:0] cos_q;

	for (genvar k = 0; k < DEPTH; k++) begin : g_tab
		localparam longint unsigned US = 4 * k;
		localparam longint unsigned QS = US / DEPTH;
		localparam longint unsigned RS0 = US % DEPTH;
		localparam longint unsigned RS = (QS % 2 == 1) ? DEPTH - RS0 : RS0;
		localparam longint unsigned XS = ppid_pkg::HALF_PI_Q30 * RS / DEPTH;
		localparam logic signed [16:0] VS = ppid_pkg::sin_poly(XS);
		localparam longint unsigned UC = (4 * k + DEPTH) % (4 * DEPTH);
		localparam longint unsigned QC = UC / DEPTH;
		localparam longint unsigned RC0 = UC % DEPTH;
		localparam longint unsigned RC = (QC % 2 == 1) ? DEPTH - RC0 : RC0;
		localparam longint unsigned XC = ppid_pkg::HALF_PI_Q30 * RC / DEPTH;
		localparam logic signed [16:0] VC = ppid_pkg::sin_poly(XC);
		assign sin_tab[k] = (QS >= 2) ? -VS : VS;
		assign cos_tab[k] = (QC >= 2) ? -VC : VC;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sin_q <= sin_tab[idx];
			cos_q <= cos_tab[idx];
		end
	end

	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

`default_nettype wire

// ----- hw/rtl/position_pid_to_attitude_setpoint.sv -----
// Top level of the position PID controller: item capture, three axis lanes,
// heading rotation, limits and integrators. Depends on ppid_pkg, ppid_lane
// and ppid_sine_rom.
//
// Each input item is one control tick and yields exactly one result item.
// An item passes from acceptance to the output register through three
// lane stages (products, force sum, integrator increment), then the sine
// table read, the four rotation products, the rotation sum and the final
// limit stage. The block works on one item at a time and takes the next one
// in the idle state that follows, so it takes no new item before the last
// one has left the limit stage. The limit stage also waits while a
// previous result is still held in the output register and stalled. A new
// item is taken as soon as the block is idle, even while the last result
// still waits to be collected. The x, y and z axes run in three parallel
// lanes; the rotation into the body frame and the clamping of pitch, roll
// and thrust merge their forces. Integrators freeze on an axis whose output
// was clamped, and the z integrator never rises above zero. Configuration
// registers must only be written while the block is idle.
`default_nettype none

module position_pid_to_attitude_setpoint #(
	parameter int SINE_TABLE_DEPTH = ppid_pkg::SINE_TABLE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire ppid_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output ppid_pkg::out_item_t       out_item,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int HN_W = 17 + DEPTH_W;
	localparam int HP_W = HN_W + 31;
	localparam int Q_W = DEPTH_W + 3;
	localparam logic signed [30:0] INV_S = 31'(ppid_pkg::INV_TWO_PI_Q32);
	localparam logic signed [HP_W-1:0] ROUND_BIAS = HP_W'(64'sd17592186044416);

	ppid_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [23:0] p_gain_xy_q, p_gain_z_q, i_gain_xy_q, i_gain_z_q;
	logic [23:0] d_gain_xy_q, d_gain_z_q;
	logic [31:0] thrust_limits_q, hover_and_tilt_q;

	ppid_pkg::in_item_t item_q;
	logic signed [31:0] integ_q [3];

	logic signed [HN_W-1:0] hn_s1;
	logic signed [HP_W-1:0] hp_s2;
	logic signed [Q_W-1:0] q_val, q_adj;
	logic [IDX_W-1:0] idx_s3;
	logic signed [16:0] sin_val, cos_val;
	logic signed [48:0] cf0_s5, sf1_s5, cf1_s5, sf0_s5;
	logic signed [49:0] sum_x, sum_y;
	logic signed [31:0] bx_s6, by_s6;

	logic out_valid_q;
	ppid_pkg::out_item_t out_item_q;

	ppid_pkg::lane_ctl_t lane_ctl;
	logic signed [31:0] tgt [3];
	logic signed [31:0] meas [3];
	logic signed [31:0] rate [3];
	logic [23:0] pg [3];
	logic [23:0] ig [3];
	logic [23:0] dg [3];
	logic signed [31:0] lane_force [3];
	logic signed [32:0] incr [3];

	logic advance;

	// Limit stage signals.
	logic [15:0] thr_min, thr_max, hover, tilt_raw;
	logic [14:0] tilt;
	logic signed [33:0] tq, pitch_c, roll_c, thrust_c, thr_lo, thr_hi;
	logic [2:0] sat;
	logic [15:0] preload;

	assign thr_min = thrust_limits_q[15:0];
	assign thr_max = thrust_limits_q[31:16];
	assign hover = hover_and_tilt_q[15:0];
	assign tilt_raw = hover_and_tilt_q[31:16];

	// The hover preload is held inside the thrust limits.
	always_comb begin
		preload = thr_min;
		if (item_q.reset_flags[2]) begin
			if (hover < thr_min) begin
				preload = thr_min;
			end else if (hover > thr_max) begin
				preload = thr_max;
			end else begin
				preload = hover;
			end
		end
	end

	// Handshake and sequencing.
	assign in_stall = (state_q != ppid_pkg::ST_IDLE);
	assign advance = (state_q == ppid_pkg::ST_CLAMP) && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		lane_ctl = '0;
		case (state_q)
			ppid_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ppid_pkg::ST_MUL;
				end
			end
			ppid_pkg::ST_MUL: begin
				lane_ctl.mul_en = 1'b1;
				state_d = ppid_pkg::ST_SUM;
			end
			ppid_pkg::ST_SUM: begin
				lane_ctl.sum_en = 1'b1;
				state_d = ppid_pkg::ST_INC;
			end
			ppid_pkg::ST_INC: begin
				lane_ctl.inc_en = 1'b1;
				state_d = ppid_pkg::ST_ROM;
			end
			ppid_pkg::ST_ROM: state_d = ppid_pkg::ST_PROD;
			ppid_pkg::ST_PROD: state_d = ppid_pkg::ST_ROT;
			ppid_pkg::ST_ROT: state_d = ppid_pkg::ST_CLAMP;
			ppid_pkg::ST_CLAMP: begin
				if (advance) begin
					state_d = ppid_pkg::ST_IDLE;
				end
			end
			default: state_d = ppid_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_item;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_xy_q <= ppid_pkg::P_GAIN_RESET;
			p_gain_z_q <= ppid_pkg::P_GAIN_RESET;
			i_gain_xy_q <= ppid_pkg::GAIN_ZERO;
			i_gain_z_q <= ppid_pkg::GAIN_ZERO;
			d_gain_xy_q <= ppid_pkg::GAIN_ZERO;
			d_gain_z_q <= ppid_pkg::GAIN_ZERO;
			thrust_limits_q <= ppid_pkg::THRUST_LIMITS_RESET;
			hover_and_tilt_q <= ppid_pkg::HOVER_TILT_RESET;
		end else if (cfg_we) begin
			case (ppid_pkg::cfg_idx_t'(cfg_index))
				ppid_pkg::CFG_P_GAIN_XY: p_gain_xy_q <= cfg_data[23:0];
				ppid_pkg::CFG_P_GAIN_Z: p_gain_z_q <= cfg_data[23:0];
				ppid_pkg::CFG_I_GAIN_XY: i_gain_xy_q <= cfg_data[23:0];
				ppid_pkg::CFG_I_GAIN_Z: i_gain_z_q <= cfg_data[23:0];
				ppid_pkg::CFG_D_GAIN_XY: d_gain_xy_q <= cfg_data[23:0];
				ppid_pkg::CFG_D_GAIN_Z: d_gain_z_q <= cfg_data[23:0];
				ppid_pkg::CFG_THRUST_LIMITS: thrust_limits_q <= cfg_data;
				ppid_pkg::CFG_HOVER_AND_TILT: hover_and_tilt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Axis lanes: x and y share the horizontal gains, z has its own.
	assign tgt[0] = item_q.target_x;
	assign tgt[1] = item_q.target_y;
	assign tgt[2] = item_q.target_z;
	assign meas[0] = item_q.measured_x;
	assign meas[1] = item_q.measured_y;
	assign meas[2] = item_q.measured_z;
	assign rate[0] = item_q.error_rate_x;
	assign rate[1] = item_q.error_rate_y;
	assign rate[2] = item_q.error_rate_z;
	assign pg[0] = p_gain_xy_q;
	assign pg[1] = p_gain_xy_q;
	assign pg[2] = p_gain_z_q;
	assign ig[0] = i_gain_xy_q;
	assign ig[1] = i_gain_xy_q;
	assign ig[2] = i_gain_z_q;
	assign dg[0] = d_gain_xy_q;
	assign dg[1] = d_gain_xy_q;
	assign dg[2] = d_gain_z_q;

	for (genvar a = 0; a < 3; a++) begin : g_lane
		ppid_lane u_lane (
			.clk       (clk),
			.ctl       (lane_ctl),
			.target    (tgt[a]),
			.measured  (meas[a]),
			.rate      (rate[a]),
			.p_gain    (pg[a]),
			.i_gain    (ig[a]),
			.d_gain    (dg[a]),
			.integ     (integ_q[a]),
			.time_step (item_q.time_step),
			.force_out (lane_force[a]),
			.incr      (incr[a])
		);
	end

	// Heading to table index: round(heading * N / 2pi), wrapped into the table.
	always_ff @(posedge clk) begin
		if (state_q == ppid_pkg::ST_MUL) begin
			hn_s1 <= item_q.heading * $signed({1'b0, DEPTH_W'(SINE_TABLE_DEPTH)});
		end
		if (state_q == ppid_pkg::ST_SUM) begin
			hp_s2 <= hn_s1 * INV_S + ROUND_BIAS;
		end
		if (state_q == ppid_pkg::ST_INC) begin
			idx_s3 <= IDX_W'(q_adj);
		end
	end

	assign q_val = Q_W'(hp_s2 >>> 45);
	assign q_adj = q_val[Q_W-1] ? q_val + Q_W'(SINE_TABLE_DEPTH) : q_val;

	ppid_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk     (clk),
		.rd_en   (state_q == ppid_pkg::ST_ROM),
		.idx     (idx_s3),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	// Rotation of the horizontal force into the body frame.
	always_ff @(posedge clk) begin
		if (state_q == ppid_pkg::ST_PROD) begin
			cf0_s5 <= cos_val * lane_force[0];
			sf1_s5 <= sin_val * lane_force[1];
			cf1_s5 <= cos_val * lane_force[1];
			sf0_s5 <= sin_val * lane_force[0];
		end
		if (state_q == ppid_pkg::ST_ROT) begin
			bx_s6 <= ppid_pkg::sat32(64'(sum_x >>> 15));
			by_s6 <= ppid_pkg::sat32(64'(sum_y >>> 15));
		end
	end

	assign sum_x = 50'(cf0_s5) + 50'(sf1_s5);
	assign sum_y = 50'(cf1_s5) - 50'(sf0_s5);

	// Limits. Thrust is raised to the minimum first, then lowered to the
	// maximum, so an inverted pair of limits gives the maximum.
	assign tilt = tilt_raw[15] ? 15'h7fff : tilt_raw[14:0];
	assign tq = 34'({tilt, 2'b00});
	assign thr_lo = 34'({thr_min, 1'b0});
	assign thr_hi = 34'({thr_max, 1'b0});

	always_comb begin
		sat = 3'b000;
		pitch_c = -34'(bx_s6);
		roll_c = 34'(by_s6);
		thrust_c = -34'(lane_force[2]);
		if (pitch_c > tq) begin
			pitch_c = tq;
			sat[0] = 1'b1;
		end else if (pitch_c < -tq) begin
			pitch_c = -tq;
			sat[0] = 1'b1;
		end
		if (roll_c > tq) begin
			roll_c = tq;
			sat[1] = 1'b1;
		end else if (roll_c < -tq) begin
			roll_c = -tq;
			sat[1] = 1'b1;
		end
		if (thrust_c < thr_lo) begin
			thrust_c = thr_lo;
			sat[2] = 1'b1;
		end
		if (thrust_c > thr_hi) begin
			thrust_c = thr_hi;
			sat[2] = 1'b1;
		end
	end

	// Integrators: reset flags act before the force sum, the update after the
	// limits, and only on axes that were not clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [31:0] nv;
		if (!arst_n) begin
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			integ_q[2] <= '0;
		end else if (state_q == ppid_pkg::ST_MUL) begin
			if (item_q.reset_flags[1]) begin
				integ_q[2] <= -32'({preload, 1'b0});
			end
			if (item_q.reset_flags[0]) begin
				integ_q[0] <= '0;
				integ_q[1] <= '0;
			end
		end else if (advance) begin
			for (int a = 0; a < 3; a++) begin
				nv = ppid_pkg::sat32(64'(34'(integ_q[a]) + 34'(incr[a])));
				if (a == 2 && nv > 0) begin
					nv = '0;
				end
				if (!sat[a]) begin
					integ_q[a] <= nv;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.roll_angle <= roll_c[17:2];
			out_item_q.pitch_angle <= pitch_c[17:2];
			out_item_q.thrust_out <= thrust_c[16:1];
			out_item_q.saturated <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	// The vertical integrator is never positive.
	a_z_integ_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q[2] <= 32'sd0)
		else $error("z integrator positive");

	// An accepted item always starts the product stage next.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ppid_pkg::ST_MUL))
		else $error("accepted item did not start");

	// Leaving the limit stage always presents a result.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid && state_q == ppid_pkg::ST_IDLE))
		else $error("result not presented");

endmodule

`default_nettype wire

// ----- tb/sv/ppid_checker.sv -----
// Checker for the position PID controller: snoops the configuration port and
// both item channels, predicts every result and compares it. Depends on ppid_pkg.
module ppid_checker
	import ppid_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire in_item_t   in_item,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire out_item_t  out_item,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	output int              mismatches,
	output int              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [23:0] kp_xy, kp_z, ki_xy, ki_z, kd_xy, kd_z;
	logic [31:0] thrust_lim, hover_tilt;
	longint integ [3];
	out_item_t setpoint_q [$];

	assign outstanding = setpoint_q.size();

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Sine of a quarter-turn fraction r/N by a truncated Taylor series, Q1.15.
	function automatic longint quarter_sine(longint unsigned r);
		longint unsigned x, x2, term;
		longint acc;
		x = HALF_PI_Q30 * r / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		return (acc + 16384) >>> 15;
	endfunction

	// u counts quarter steps of a table entry: the full turn is 4N.
	function automatic longint table_sine(longint unsigned u);
		longint unsigned quad, r;
		longint v;
		u = u % (4 * SINE_TABLE_DEPTH);
		quad = u / SINE_TABLE_DEPTH;
		r = u % SINE_TABLE_DEPTH;
		if (quad % 2 == 1) r = SINE_TABLE_DEPTH - r;
		v = quarter_sine(r);
		return (quad >= 2) ? -v : v;
	endfunction

	function automatic out_item_t control_tick(in_item_t it);
		longint err [3], rate [3], force_v [3], kp [3], ki [3], kd [3];
		longint tmin, tmax, hover, tilt, pre, q, idx, s, c, bx, by;
		longint pitch, roll, thrust, tq, inc, v;
		logic [2:0] sat;
		out_item_t r;
		tmin = longint'(thrust_lim[15:0]);
		tmax = longint'(thrust_lim[31:16]);
		hover = longint'(hover_tilt[15:0]);
		tilt = longint'(hover_tilt[31:16]);
		if (tilt > 32767) tilt = 32767;
		kp[0] = longint'(kp_xy); kp[1] = longint'(kp_xy); kp[2] = longint'(kp_z);
		ki[0] = longint'(ki_xy); ki[1] = longint'(ki_xy); ki[2] = longint'(ki_z);
		kd[0] = longint'(kd_xy); kd[1] = longint'(kd_xy); kd[2] = longint'(kd_z);
		sat = '0;
		if (it.reset_flags[1]) begin
			pre = tmin;
			if (it.reset_flags[2]) begin
				pre = hover;
				if (pre < tmin) pre = tmin;
				else if (pre > tmax) pre = tmax;
			end
			integ[2] = -(pre * 2);
		end
		if (it.reset_flags[0]) begin
			integ[0] = 0;
			integ[1] = 0;
		end
		err[0] = longint'(it.target_x) - longint'(it.measured_x);
		err[1] = longint'(it.target_y) - longint'(it.measured_y);
		err[2] = longint'(it.target_z) - longint'(it.measured_z);
		rate[0] = longint'(it.error_rate_x);
		rate[1] = longint'(it.error_rate_y);
		rate[2] = longint'(it.error_rate_z);
		for (int a = 0; a < 3; a++)
			force_v[a] = clip32(((err[a] * kp[a]) >>> 16) + ((rate[a] * kd[a]) >>> 16)
				+ integ[a]);
		// Nearest table index for the heading, wrapped into the table.
		q = (longint'(it.heading) * SINE_TABLE_DEPTH * INV_TWO_PI_Q32 + (64'sd1 <<< 44))
			>>> 45;
		idx = q % SINE_TABLE_DEPTH;
		if (idx < 0) idx += SINE_TABLE_DEPTH;
		s = table_sine(idx * 4);
		c = table_sine(idx * 4 + SINE_TABLE_DEPTH);
		bx = clip32((c * force_v[0] + s * force_v[1]) >>> 15);
		by = clip32((c * force_v[1] - s * force_v[0]) >>> 15);
		pitch = -bx;
		roll = by;
		thrust = -force_v[2];
		tq = tilt * 4;
		if (pitch > tq) begin pitch = tq; sat[0] = 1'b1; end
		else if (pitch < -tq) begin pitch = -tq; sat[0] = 1'b1; end
		if (roll > tq) begin roll = tq; sat[1] = 1'b1; end
		else if (roll < -tq) begin roll = -tq; sat[1] = 1'b1; end
		if (thrust < tmin * 2) begin thrust = tmin * 2; sat[2] = 1'b1; end
		if (thrust > tmax * 2) begin thrust = tmax * 2; sat[2] = 1'b1; end
		for (int a = 0; a < 3; a++) begin
			if (!sat[a]) begin
				inc = clip32((err[a] * ki[a]) >>> 16);
				inc = (inc * longint'(it.time_step)) >>> 24;
				v = clip32(integ[a] + inc);
				if (a == 2 && v > 0) v = 0;
				integ[a] = v;
			end
		end
		r.roll_angle = 16'(roll >>> 2);
		r.pitch_angle = 16'(pitch >>> 2);
		r.thrust_out = 16'(thrust >>> 1);
		r.saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			kp_xy <= P_GAIN_RESET;
			kp_z <= P_GAIN_RESET;
			ki_xy <= GAIN_ZERO;
			ki_z <= GAIN_ZERO;
			kd_xy <= GAIN_ZERO;
			kd_z <= GAIN_ZERO;
			thrust_lim <= THRUST_LIMITS_RESET;
			hover_tilt <= HOVER_TILT_RESET;
			integ[0] = 0;
			integ[1] = 0;
			integ[2] = 0;
			setpoint_q.delete();
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_P_GAIN_XY: kp_xy <= cfg_data[23:0];
					CFG_P_GAIN_Z: kp_z <= cfg_data[23:0];
					CFG_I_GAIN_XY: ki_xy <= cfg_data[23:0];
					CFG_I_GAIN_Z: ki_z <= cfg_data[23:0];
					CFG_D_GAIN_XY: kd_xy <= cfg_data[23:0];
					CFG_D_GAIN_Z: kd_z <= cfg_data[23:0];
					CFG_THRUST_LIMITS: thrust_lim <= cfg_data;
					CFG_HOVER_AND_TILT: hover_tilt <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				setpoint_q.push_back(control_tick(in_item));
			if (out_valid && !out_stall) begin
				if (setpoint_q.size() == 0) begin
					$display("%t: unexpected result, expected none, actual %p", $realtime,
						out_item);
					mismatches <= mismatches + 1;
				end else begin
					want = setpoint_q.pop_front();
					if (out_item !== want) begin
						$display("%t: result mismatch, expected %p, actual %p", $realtime,
							want, out_item);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end
endmodule

// ----- tb/sv/position_pid_to_attitude_setpoint_tb.sv -----
// Testbench top for the position PID controller: clock, reset, stimulus and
// verdict. Depends on ppid_pkg, ppid_checker and the controller RTL.
module position_pid_to_attitude_setpoint_tb;
	import ppid_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_we;
	in_item_t in_item;
	out_item_t out_item;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	int mismatches, outstanding;
	int quiet_cycles;
	// When set, neither side idles: this gives the long stretch at full rate.
	bit no_idle;

	position_pid_to_attitude_setpoint i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ppid_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random, with a probability of 19 in 100, unless idling is off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 19);
		end
	end

	// Watchdog: any accepted item on either side restarts the count, so a
	// stuck handshake ends the run well within the cycle budget.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 5000) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A position value: mostly a few metres, sometimes an extreme or any value,
	// so that both the linear region and the saturating corners are reached.
	function automatic logic [31:0] pick_pos();
		case ($urandom_range(9))
			0: return $urandom();
			1: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic in_item_t random_tick();
		in_item_t it;
		it.target_x = pick_pos();
		it.target_y = pick_pos();
		it.target_z = pick_pos();
		it.measured_x = pick_pos();
		it.measured_y = pick_pos();
		it.measured_z = pick_pos();
		it.error_rate_x = pick_pos();
		it.error_rate_y = pick_pos();
		it.error_rate_z = pick_pos();
		it.heading = 16'($urandom());
		it.time_step = ($urandom_range(9) == 0) ? 24'hffffff : 24'($urandom_range(1 << 18));
		// Preloads and integrator clears are occasional, as in a real flight.
		it.reset_flags = ($urandom_range(9) < 3) ? 3'($urandom_range(7)) : 3'd0;
		return it;
	endfunction

	// Offers one item, at times after a random gap unless idling is off, and returns
	// once it has been taken. Valid stays high between back-to-back items.
	task automatic offer_tick(input in_item_t it);
		if (!no_idle && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 50) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Registers are only written with the block idle: every result collected
	// and then a further wait for good measure.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic write_gains(input logic [23:0] kp_xy, kp_z, ki_xy, ki_z, kd_xy, kd_z);
		write_reg(CFG_P_GAIN_XY, {8'd0, kp_xy});
		write_reg(CFG_P_GAIN_Z, {8'd0, kp_z});
		write_reg(CFG_I_GAIN_XY, {8'd0, ki_xy});
		write_reg(CFG_I_GAIN_Z, {8'd0, ki_z});
		write_reg(CFG_D_GAIN_XY, {8'd0, kd_xy});
		write_reg(CFG_D_GAIN_Z, {8'd0, kd_z});
	endtask

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_P_GAIN_XY;
		cfg_data = '0;
		no_idle = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under the reset settings: field extremes, every
		// combination of the reset flags, and headings at both extremes, zero and a quarter turn.
		for (int k = 0; k < 8; k++) begin
			it = random_tick();
			it.reset_flags = 3'(k);
			offer_tick(it);
		end
		it = '0;
		it.target_x = 32'h7fffffff;
		it.measured_x = 32'h80000000;
		it.target_y = 32'h80000000;
		it.measured_y = 32'h7fffffff;
		it.target_z = 32'h7fffffff;
		it.measured_z = 32'h80000000;
		it.error_rate_x = 32'h7fffffff;
		it.error_rate_y = 32'h80000000;
		it.error_rate_z = 32'h80000000;
		it.heading = 16'sh8000;
		it.time_step = 24'hffffff;
		offer_tick(it);
		it.heading = 16'sh7fff;
		it.target_x = 32'h80000000;
		it.measured_x = 32'h7fffffff;
		offer_tick(it);
		it = '0;
		offer_tick(it);
		it.heading = 16'sd12868;
		it.target_x = 32'sd65536;
		offer_tick(it);
		drain();

		// All gains at their largest, with a tilt beyond the angle range and the
		// minimum thrust above the maximum.
		write_gains(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
		write_reg(CFG_THRUST_LIMITS, {16'd1000, 16'd30000});
		write_reg(CFG_HOVER_AND_TILT, {16'hffff, 16'd20000});
		cfg_we <= 1'b0;
		for (int k = 0; k < 8; k++) begin
			it = random_tick();
			it.reset_flags = 3'(k);
			offer_tick(it);
		end
		drain();

		// Random phases, each under a fresh setting; all gains at zero, with
		// zero tilt and a full thrust range, make up one of them. The third
		// phase runs without any idling on either side.
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 1) begin
				write_gains('0, '0, '0, '0, '0, '0);
				write_reg(CFG_THRUST_LIMITS, 32'hffff0000);
				write_reg(CFG_HOVER_AND_TILT, 32'h00000000);
			end else begin
				write_gains(24'($urandom_range(1 << 18)), 24'($urandom_range(1 << 18)),
					24'($urandom_range(1 << 16)), 24'($urandom_range(1 << 16)),
					24'($urandom_range(1 << 16)), 24'($urandom_range(1 << 16)));
				write_reg(CFG_THRUST_LIMITS, {16'($urandom_range(16384, 32768)),
					16'($urandom_range(8192))});
				write_reg(CFG_HOVER_AND_TILT, $urandom());
			end
			cfg_we <= 1'b0;
			no_idle = (phase == 2);
			for (int k = 0; k < 135; k++) offer_tick(random_tick());
			no_idle = 1'b0;
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
